[rtl/tflc_pkg.sv]
// Shared types and constants for the throttle filter and lamp controller.
package tflc_pkg;

    // Field widths
    localparam int SampleW = 12;
    localparam int TimeW   = 32;
    localparam int DutyW   = 5;
    localparam int OffsetW = 6;
    localparam int HoldW   = 16;
    localparam int AccW    = 13;

    // Largest duty value
    localparam logic [DutyW-1:0] DutyMax = 5'd31;

    // Register indexes on the config port
    localparam logic CFG_THROTTLE_OFFSET = 1'b0;
    localparam logic CFG_BRAKE_HOLD      = 1'b1;

    // Reset values of the config registers
    localparam logic [OffsetW-1:0] OffsetReset = 6'd9;
    localparam logic [HoldW-1:0]   HoldReset   = 16'd500;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } motor_dir_t;

    typedef enum logic [2:0] {
        STRIP_OFF     = 3'd0,
        STRIP_ENGINE  = 3'd1,
        STRIP_GREEN   = 3'd2,
        STRIP_RED     = 3'd3,
        STRIP_RAINBOW = 3'd4
    } strip_mode_t;

    // Switch and gear inputs of one request
    typedef struct packed {
        logic master_on;
        logic head_switch;
        logic left_switch;
        logic right_switch;
        logic gear_forward;
        logic gear_reverse;
        logic obstacle;
    } sw_t;

    // One result
    typedef struct packed {
        motor_dir_t       motor_dir;
        logic [DutyW-1:0] motor_duty;
        logic [DutyW-1:0] raw_duty;
        logic             head_lamp;
        logic             left_lamp;
        logic             right_lamp;
        logic             tail_lamp;
        logic             fan_on;
        strip_mode_t      strip_mode;
        logic [DutyW-1:0] strip_level;
    } result_t;

endpackage

[rtl/tflc_duty.sv]
// Raw duty: throttle sample cut to two decimal digits, offset removed, capped.
module tflc_duty
    import tflc_pkg::*;
(
    input  logic [SampleW-1:0] throttle_sample,
    input  logic [OffsetW-1:0] throttle_offset,
    output logic [DutyW-1:0]   raw_duty
);

    // Thousands*10 + hundreds digit equals sample / 100.
    // Reciprocal 5243 / 2^19 is exact for every 12-bit sample.
    localparam logic [12:0] Recip100 = 13'd5243;
    localparam int          Shift100 = 19;

    logic [24:0]        prod;
    logic [OffsetW-1:0] gas;
    logic [OffsetW-1:0] diff;

    always_comb
    begin
        prod = 25'(throttle_sample) * 25'(Recip100);
        gas  = prod[Shift100 + OffsetW - 1:Shift100];

        // Subtract offset with floor at zero, then saturate
        if (gas > throttle_offset)
        begin
            diff = gas - throttle_offset;
        end
        else
        begin
            diff = '0;
        end

        if (diff > OffsetW'(DutyMax))
        begin
            raw_duty = DutyMax;
        end
        else
        begin
            raw_duty = diff[DutyW-1:0];
        end
    end

endmodule

[rtl/tflc_core.sv]
// Moving-average filter, gear logic, lamp state and the result register.
module tflc_core
    import tflc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [DutyW-1:0]   raw_duty,
    input  logic [TimeW-1:0]   now_ms,
    input  sw_t                sw,
    input  logic [HoldW-1:0]   brake_hold_ms,
    output result_t            res
);

    // x / 12 as (x * 43691) >> 19, exact for x below 2^17
    localparam logic [15:0] Recip12 = 16'd43691;
    localparam int          Shift12 = 19;
    localparam logic [13:0] Half    = 14'd128;

    logic [AccW-1:0]  acc_reg, acc_next;
    logic [DutyW-1:0] prev_reg, prev_next;
    logic [TimeW-1:0] stamp_reg, stamp_next;
    logic             tail_reg, tail_next;
    motor_dir_t       dir_reg, dir_next;
    logic [DutyW-1:0] duty_reg, duty_next;
    result_t          res_reg, res_next;

    logic [16:0]      mix;
    logic [32:0]      quot_prod;
    logic [13:0]      round_sum;
    logic [5:0]       filt_wide;
    logic [DutyW-1:0] filt;
    logic [TimeW-1:0] elapsed;

    // Filter update: acc' = (acc*11 + raw*256) / 12, filtered = round(acc'/256)
    always_comb
    begin
        mix       = (17'(acc_reg) << 3) + (17'(acc_reg) << 1) + 17'(acc_reg)
                  + (17'(raw_duty) << 8);
        quot_prod = 33'(mix) * 33'(Recip12);
        acc_next  = quot_prod[Shift12 + AccW - 1:Shift12];
        round_sum = 14'(acc_next) + Half;
        filt_wide = round_sum[13:8];
        if (filt_wide > 6'(DutyMax))
        begin
            filt = DutyMax;
        end
        else
        begin
            filt = filt_wide[DutyW-1:0];
        end
    end

    // Gear, motor and lamp decisions
    always_comb
    begin
        prev_next  = prev_reg;
        stamp_next = stamp_reg;
        tail_next  = tail_reg;
        dir_next   = dir_reg;
        duty_next  = duty_reg;
        elapsed    = now_ms - stamp_reg;

        res_next             = '0;
        res_next.raw_duty    = raw_duty;
        res_next.strip_mode  = STRIP_OFF;

        if (sw.master_on)
        begin
            res_next.head_lamp  = sw.head_switch;
            res_next.left_lamp  = sw.left_switch;
            res_next.right_lamp = sw.right_switch;
            if (sw.gear_forward)
            begin
                dir_next  = DIR_FWD;
                duty_next = filt;
                // Deceleration lights the tail lamp for the hold time
                if (filt < prev_reg)
                begin
                    tail_next  = 1'b1;
                    stamp_next = now_ms;
                end
                else if (elapsed >= TimeW'(brake_hold_ms))
                begin
                    tail_next = 1'b0;
                end
                prev_next            = filt;
                res_next.strip_mode  = STRIP_ENGINE;
                res_next.strip_level = filt;
                res_next.fan_on      = 1'b1;
            end
            else if (sw.gear_reverse)
            begin
                if (!sw.obstacle)
                begin
                    dir_next            = DIR_REV;
                    duty_next           = filt;
                    res_next.strip_mode = STRIP_GREEN;
                end
                else
                begin
                    dir_next            = DIR_STOP;
                    duty_next           = '0;
                    res_next.strip_mode = STRIP_RED;
                end
                tail_next           = 1'b1;
                res_next.left_lamp  = 1'b1;
                res_next.right_lamp = 1'b1;
            end
            else
            begin
                // Park
                dir_next            = DIR_STOP;
                duty_next           = '0;
                tail_next           = 1'b1;
                res_next.fan_on     = 1'b1;
                res_next.strip_mode = STRIP_RAINBOW;
            end
        end
        else
        begin
            // Master off keeps the last motor command
            tail_next = 1'b0;
        end

        res_next.motor_dir  = dir_next;
        res_next.motor_duty = duty_next;
        res_next.tail_lamp  = tail_next;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            prev_reg  <= '0;
            stamp_reg <= '0;
            tail_reg  <= 1'b0;
            dir_reg   <= DIR_STOP;
            duty_reg  <= '0;
        end
        else if (load)
        begin
            acc_reg   <= acc_next;
            prev_reg  <= prev_next;
            stamp_reg <= stamp_next;
            tail_reg  <= tail_next;
            dir_reg   <= dir_next;
            duty_reg  <= duty_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

[rtl/throttle_filter_lamp_controller_top.sv]
// Top level of the throttle filter and lamp controller.
//
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, sample, time, switches | into block
//  out     | out_valid, out_ready, motor/lamp/strip     | out of block
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | into block
//
// One request per clock while the output is not stalled; three register stages
// (input, raw duty, result), which each request passes through in that order.
// Filter and lamp state change only as a request enters the result register.
// A stalled output holds its result; each stage keeps moving while the next
// one has room, so a full pipeline holds three requests.
// Reset sets offset 9, hold 500 ms, clears the filter, lamp and motor state.
module throttle_filter_lamp_controller_top
    import tflc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [SampleW-1:0] throttle_sample,
    input  logic [TimeW-1:0]   now_ms,
    input  logic               master_on,
    input  logic               head_switch,
    input  logic               left_switch,
    input  logic               right_switch,
    input  logic               gear_forward,
    input  logic               gear_reverse,
    input  logic               obstacle,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         motor_dir,
    output logic [DutyW-1:0]   motor_duty,
    output logic [DutyW-1:0]   raw_duty,
    output logic               head_lamp,
    output logic               left_lamp,
    output logic               right_lamp,
    output logic               tail_lamp,
    output logic               fan_on,
    output logic [2:0]         strip_mode,
    output logic [DutyW-1:0]   strip_level,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [HoldW-1:0]   cfg_data
);

    logic [OffsetW-1:0] offset_reg;
    logic [HoldW-1:0]   hold_reg;

    logic               v1_reg, v2_reg, vout_reg;
    logic [SampleW-1:0] sample1_reg;
    logic [TimeW-1:0]   now1_reg, now2_reg;
    sw_t                sw1_reg, sw2_reg;
    logic [DutyW-1:0]   raw2_reg;

    logic               out_load, s2_free, s2_load, in_take;
    logic [DutyW-1:0]   raw_calc;
    result_t            res;

    // Configuration registers; writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OffsetReset;
            hold_reg   <= HoldReset;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_THROTTLE_OFFSET: offset_reg <= cfg_data[OffsetW-1:0];
                CFG_BRAKE_HOLD:      hold_reg   <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Pipeline flow control
    assign out_load = v2_reg && (!vout_reg || out_ready);
    assign s2_free  = !v2_reg || out_load;
    assign s2_load  = v1_reg && s2_free;
    assign in_ready = !v1_reg || s2_free;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                v1_reg <= in_valid;
            end
            if (s2_free)
            begin
                v2_reg <= v1_reg;
            end
            if (!vout_reg || out_ready)
            begin
                vout_reg <= v2_reg;
            end
        end
    end

    // Input stage
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample1_reg <= throttle_sample;
            now1_reg    <= now_ms;
            sw1_reg     <= '{master_on:    master_on,
                             head_switch:  head_switch,
                             left_switch:  left_switch,
                             right_switch: right_switch,
                             gear_forward: gear_forward,
                             gear_reverse: gear_reverse,
                             obstacle:     obstacle};
        end
    end

    // Raw duty stage
    tflc_duty u_duty (
        .throttle_sample (sample1_reg),
        .throttle_offset (offset_reg),
        .raw_duty        (raw_calc)
    );

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            raw2_reg <= raw_calc;
            now2_reg <= now1_reg;
            sw2_reg  <= sw1_reg;
        end
    end

    // Filter, gear logic and result register
    tflc_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .raw_duty      (raw2_reg),
        .now_ms        (now2_reg),
        .sw            (sw2_reg),
        .brake_hold_ms (hold_reg),
        .res           (res)
    );

    assign out_valid   = vout_reg;
    assign motor_dir   = res.motor_dir;
    assign motor_duty  = res.motor_duty;
    assign raw_duty    = res.raw_duty;
    assign head_lamp   = res.head_lamp;
    assign left_lamp   = res.left_lamp;
    assign right_lamp  = res.right_lamp;
    assign tail_lamp   = res.tail_lamp;
    assign fan_on      = res.fan_on;
    assign strip_mode  = res.strip_mode;
    assign strip_level = res.strip_level;

endmodule

[verif/throttle_filter_lamp_controller_top_tb.sv]
// Testbench for the throttle filter and lamp controller: predicted control passes vs. DUT results.
module throttle_filter_lamp_controller_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tflc_pkg::*;

    // One control pass as sent to the block
    typedef struct packed {
        logic [SampleW-1:0] sample;
        logic [TimeW-1:0]   now;
        sw_t                sw;
    } pass_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [SampleW-1:0] throttle_sample = '0;
    logic [TimeW-1:0]   now_ms = '0;
    logic               master_on = 1'b0;
    logic               head_switch = 1'b0;
    logic               left_switch = 1'b0;
    logic               right_switch = 1'b0;
    logic               gear_forward = 1'b0;
    logic               gear_reverse = 1'b0;
    logic               obstacle = 1'b0;

    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         motor_dir;
    logic [DutyW-1:0]   motor_duty;
    logic [DutyW-1:0]   raw_duty;
    logic               head_lamp;
    logic               left_lamp;
    logic               right_lamp;
    logic               tail_lamp;
    logic               fan_on;
    logic [2:0]         strip_mode;
    logic [DutyW-1:0]   strip_level;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = CFG_THROTTLE_OFFSET;
    logic [HoldW-1:0]   cfg_data = '0;

    throttle_filter_lamp_controller_top dut (.*);

    // Predictor state and its copy of the registers
    logic [OffsetW-1:0] cfg_offset = OffsetReset;
    logic [HoldW-1:0]   cfg_hold   = HoldReset;
    logic [AccW-1:0]    ema_acc    = '0;
    logic [DutyW-1:0]   last_filt  = '0;
    logic [TimeW-1:0]   brake_time = '0;
    logic               tail_on    = 1'b0;
    motor_dir_t         dir_hold   = DIR_STOP;
    logic [DutyW-1:0]   duty_hold  = '0;

    result_t predicted_drives[$];
    int      error_count = 0;

    // Stimulus walk: running time base and throttle position
    logic [TimeW-1:0]   clock_ms = '0;
    int                 throttle_pos = 0;

    // Receiver control: 0 always ready, 1 light stalls, 2 heavy stalls
    int                 rx_mode = 0;
    int                 rx_hold_cycles = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= 100)
            $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Expected drives for one control pass; updates filter, lamp and motor state
    function automatic result_t run_control_pass(input pass_t p);
        int unsigned      gas;
        int unsigned      raw;
        int unsigned      acc_next;
        int unsigned      filt;
        logic [TimeW-1:0] elapsed;
        result_t          r;

        gas = (p.sample / 1000) * 10 + (p.sample / 100) % 10;
        raw = (gas > cfg_offset) ? gas - cfg_offset : 0;
        if (raw > DutyMax)
            raw = 32'(DutyMax);

        // EMA with alpha 1/12, 8 fractional bits, runs on every pass
        acc_next = (int'(ema_acc) * 11 + raw * 256) / 12;
        ema_acc  = AccW'(acc_next);
        filt     = (int'(ema_acc) + 128) / 256;
        if (filt > DutyMax)
            filt = 32'(DutyMax);

        r = '0;
        r.motor_dir  = DIR_STOP;
        r.strip_mode = STRIP_OFF;

        if (p.sw.master_on)
        begin
            r.head_lamp  = p.sw.head_switch;
            r.left_lamp  = p.sw.left_switch;
            r.right_lamp = p.sw.right_switch;
            if (p.sw.gear_forward)
            begin
                dir_hold  = DIR_FWD;
                duty_hold = DutyW'(filt);
                // deceleration lights the brake lamp and restarts the hold time
                elapsed = p.now - brake_time;
                if (filt < last_filt)
                begin
                    tail_on    = 1'b1;
                    brake_time = p.now;
                end
                else if (elapsed >= cfg_hold)
                begin
                    tail_on = 1'b0;
                end
                last_filt     = DutyW'(filt);
                r.strip_mode  = STRIP_ENGINE;
                r.strip_level = DutyW'(filt);
                r.fan_on      = 1'b1;
            end
            else if (p.sw.gear_reverse)
            begin
                if (!p.sw.obstacle)
                begin
                    dir_hold     = DIR_REV;
                    duty_hold    = DutyW'(filt);
                    r.strip_mode = STRIP_GREEN;
                end
                else
                begin
                    dir_hold     = DIR_STOP;
                    duty_hold    = '0;
                    r.strip_mode = STRIP_RED;
                end
                tail_on      = 1'b1;
                r.left_lamp  = 1'b1;
                r.right_lamp = 1'b1;
            end
            else
            begin
                dir_hold     = DIR_STOP;
                duty_hold    = '0;
                tail_on      = 1'b1;
                r.fan_on     = 1'b1;
                r.strip_mode = STRIP_RAINBOW;
            end
        end
        else
        begin
            tail_on = 1'b0;
        end

        r.motor_dir  = dir_hold;
        r.motor_duty = duty_hold;
        r.raw_duty   = raw[DutyW-1:0];
        r.tail_lamp  = tail_on;
        return r;
    endfunction

    // Next request: a plausible drive with random content, or pure noise
    function automatic pass_t next_pass(input bit noisy);
        pass_t       p;
        int unsigned pick;

        p.sample = SampleW'($urandom_range(0, 4095));
        p.now    = $urandom;
        p.sw     = sw_t'(7'($urandom_range(0, 127)));
        if (noisy)
            return p;

        // time mostly moves forward around the brake hold time, sometimes jumps
        pick = $urandom_range(0, 99);
        if (pick < 70)
            clock_ms += $urandom_range(0, 200);
        else if (pick < 90)
            clock_ms += $urandom_range(200, 900);
        else if (pick < 97)
            clock_ms += $urandom_range(0, 2);
        else
            clock_ms = $urandom;

        // throttle wanders so the filter both rises and falls
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            throttle_pos = $urandom_range(0, 4095);
        end
        else
        begin
            throttle_pos += int'($urandom_range(0, 800)) - 400;
            if (throttle_pos < 0)
                throttle_pos = 0;
            if (throttle_pos > 4095)
                throttle_pos = 4095;
        end

        p.sample          = SampleW'(throttle_pos);
        p.now             = clock_ms;
        p.sw.master_on    = ($urandom_range(0, 99) < 92);
        pick = $urandom_range(0, 99);
        p.sw.gear_forward = (pick < 60);
        p.sw.gear_reverse = (pick < 60) ? 1'($urandom_range(0, 1)) : (pick < 85);
        return p;
    endfunction

    function automatic pass_t make_pass(input int sample, input logic [TimeW-1:0] t,
                                        input logic [6:0] sw_bits);
        pass_t p;
        p.sample = SampleW'(sample);
        p.now    = t;
        p.sw     = sw_t'(sw_bits);
        return p;
    endfunction

    // Send one request; valid stays up from the previous request if there was no gap
    task automatic send_pass(input pass_t p);
        @(negedge clk);
        throttle_sample = p.sample;
        now_ms          = p.now;
        master_on       = p.sw.master_on;
        head_switch     = p.sw.head_switch;
        left_switch     = p.sw.left_switch;
        right_switch    = p.sw.right_switch;
        gear_forward    = p.sw.gear_forward;
        gear_reverse    = p.sw.gear_reverse;
        obstacle        = p.sw.obstacle;
        in_valid        = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predicted_drives.push_back(run_control_pass(p));
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Bursts of requests with optional random gaps between them
    task automatic send_stream(input int count, input bit gaps, input int noise_pct);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_pass(next_pass($urandom_range(0, 99) < noise_pct));
                sent++;
            end
            if (gaps && $urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 6));
        end
    endtask

    // Stop sending, let every result drain, then allow for pipeline latency
    task automatic wait_idle();
        idle_sender(1);
        while (predicted_drives.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [HoldW-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_THROTTLE_OFFSET)
            cfg_offset = data[OffsetW-1:0];
        else
            cfg_hold = data;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Receiver: long hold-off when asked, otherwise a stall pattern per mode
    initial
    begin
        logic [15:0] pattern;
        int          pos;
        pattern = '1;
        pos     = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_ready = 1'b0;
                rx_hold_cycles--;
            end
            else if (rx_mode == 0)
            begin
                out_ready = 1'b1;
            end
            else
            begin
                if (pos == 0)
                    pattern = (rx_mode == 1) ? 16'($urandom | $urandom)
                                             : 16'($urandom & $urandom);
                out_ready = pattern[pos];
                pos = (pos + 1) % 16;
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_drives.size() == 0)
            begin
                report_mismatch("result with nothing expected", 1, 0);
            end
            else
            begin
                want = predicted_drives.pop_front();
                if (motor_dir !== want.motor_dir)
                    report_mismatch("motor_dir", motor_dir, want.motor_dir);
                if (motor_duty !== want.motor_duty)
                    report_mismatch("motor_duty", motor_duty, want.motor_duty);
                if (raw_duty !== want.raw_duty)
                    report_mismatch("raw_duty", raw_duty, want.raw_duty);
                if (head_lamp !== want.head_lamp)
                    report_mismatch("head_lamp", head_lamp, want.head_lamp);
                if (left_lamp !== want.left_lamp)
                    report_mismatch("left_lamp", left_lamp, want.left_lamp);
                if (right_lamp !== want.right_lamp)
                    report_mismatch("right_lamp", right_lamp, want.right_lamp);
                if (tail_lamp !== want.tail_lamp)
                    report_mismatch("tail_lamp", tail_lamp, want.tail_lamp);
                if (fan_on !== want.fan_on)
                    report_mismatch("fan_on", fan_on, want.fan_on);
                if (strip_mode !== want.strip_mode)
                    report_mismatch("strip_mode", strip_mode, want.strip_mode);
                if (strip_level !== want.strip_level)
                    report_mismatch("strip_level", strip_level, want.strip_level);
            end
        end
    end

    // Switch bit order below: master, head, left, right, forward, reverse, obstacle
    task automatic test_directed_cases();
        rx_mode = 1;
        send_pass(make_pass(0,    32'd0,  7'b1000100));  // zero throttle
        send_pass(make_pass(999,  32'd10, 7'b1100100));  // floors at offset
        send_pass(make_pass(1000, 32'd20, 7'b1011100));
        // full throttle ramp, then sharp drop to light the brake lamp
        for (int i = 0; i < 5; i++)
            send_pass(make_pass(4095, 32'd30 + 10 * i, 7'b1111100));
        send_pass(make_pass(3099, 32'd80,  7'b1000100));
        send_pass(make_pass(0,    32'd90,  7'b1000100));
        send_pass(make_pass(0,    32'd200, 7'b1000100));
        // reverse clear, reverse blocked, both gears, park
        send_pass(make_pass(1999, 32'd300, 7'b1000010));
        send_pass(make_pass(1999, 32'd310, 7'b1000011));
        send_pass(make_pass(2500, 32'd320, 7'b1000110));
        send_pass(make_pass(2500, 32'd330, 7'b1111000));
        // master off keeps the last motor command
        send_pass(make_pass(4095, 32'd340, 7'b0111100));
        send_pass(make_pass(4095, 32'd350, 7'b1000100));
        send_pass(make_pass(4095, 32'd360, 7'b0000101));
        // time wraps through zero
        send_pass(make_pass(100, 32'hFFFF_FF00, 7'b1000100));
        send_pass(make_pass(0,   32'h0000_0100, 7'b1000100));
        // zero offset: two-digit value above 31 saturates
        wait_idle();
        write_reg(CFG_THROTTLE_OFFSET, 16'd0);
        send_pass(make_pass(4095, 32'h200, 7'b1000100));
        send_pass(make_pass(3999, 32'h210, 7'b1000010));
        wait_idle();
        write_reg(CFG_THROTTLE_OFFSET, HoldW'(OffsetReset));
    endtask

    // Several register settings, extremes included, each with random traffic
    task automatic test_register_settings();
        int unsigned off;
        int unsigned hold;
        for (int s = 0; s < 6; s++)
        begin
            case (s)
                0:
                begin
                    off = 0;  hold = 0;
                end
                1:
                begin
                    off = 40; hold = 65535;
                end
                2:
                begin
                    off = 0;  hold = 65535;
                end
                3:
                begin
                    off = 40; hold = 0;
                end
                4:
                begin
                    off = 9;  hold = 500;
                end
                default:
                begin
                    off  = $urandom_range(0, 40);
                    hold = $urandom_range(0, 65535);
                end
            endcase
            wait_idle();
            write_reg(CFG_THROTTLE_OFFSET, HoldW'(off));
            write_reg(CFG_BRAKE_HOLD, HoldW'(hold));
            rx_mode = s % 3;
            send_stream(55, 1'b1, 5);
        end
    endtask

    // Receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        wait_idle();
        rx_mode = 0;
        rx_hold_cycles = 80;
        send_stream(30, 1'b0, 0);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        for (int chunk = 0; chunk < 5; chunk++)
        begin
            rx_mode = chunk % 3;
            send_stream(100, chunk != 2, 10);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_register_settings();
        test_output_backpressure();
        test_random_traffic();

        // drain with a bound, then allow for latency
        idle_sender(1);
        for (int n = 0; n < 5000 && predicted_drives.size() != 0; n++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (predicted_drives.size() != 0)
            report_mismatch("results never delivered", predicted_drives.size(), 0);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
rtl/tflc_pkg.sv
rtl/tflc_duty.sv
rtl/tflc_core.sv
rtl/throttle_filter_lamp_controller_top.sv
verif/throttle_filter_lamp_controller_top_tb.sv
